// File: hw/rtl/lge_pkg.sv
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types, constants and helpers of the life grid engine.
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int MaxSide   = 256;
  localparam int IdxW      = $clog2(MaxSide);
  localparam int AddrW     = 2 * IdxW;
  localparam int GridDepth = MaxSide * MaxSide;
  localparam int SideW     = IdxW + 1;
  localparam int MaxRadius = 50;
  localparam int CoordW    = 10;
  localparam int RadW      = 6;
  localparam int CountW    = 17;
  localparam int GenW      = 32;
  localparam int CacheW    = 2;

  // register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_PAINT = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RECOUNT,
    S_RCDRAIN,
    S_CELL_RD,
    S_CELL_WR,
    S_PAINT_RD,
    S_PAINT_WR,
    S_GEN,
    S_GEN_TAIL,
    S_FINISH
  } state_t;

  // side register value forced into 3..MaxSide
  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
    logic [SideW-1:0] res;
    res = v;
    if (v < SideW'(3)) res = SideW'(3);
    else if (v > SideW'(MaxSide)) res = SideW'(MaxSide);
    return res;
  endfunction

  // B3/S23 rule
  function automatic logic life_rule(input logic alive, input logic [3:0] k);
    return (k == 4'd3) || (alive && (k == 4'd2));
  endfunction

endpackage

// File: hw/rtl/lge_ram.sv
// ----------------------------------------------------------------------------
// lge_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lge_ram #(
  parameter int Width = 1,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/life_grid_engine_core.sv
// ----------------------------------------------------------------------------
// life_grid_engine_core
// Toroidal B3/S23 life grid kept in a bit RAM, with cell write, square
// paint, cell read and single generation step actions.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready    | action, col, row, cell_value, radius
//  out     | out       | out_valid / out_ready  | cell_read, population, generation
//
// write and read pass through a read state and a write state; paint reads and
// writes each cell of the square inside the grid. a step sweeps the grid RAM
// (three reads per cell through its single read port) and then runs a full
// pass over the grid RAM that clears cells outside the grid.
// after reset a pass clears the grid RAM; after a register write a recount
// pass runs. in_ready is low during both passes.
// a result waiting on out_ready holds only the final state of the next word.
// ----------------------------------------------------------------------------
module life_grid_engine_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [lge_pkg::SideW-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [lge_pkg::CoordW-1:0]    col,
  input  logic [lge_pkg::CoordW-1:0]    row,
  input  logic                          cell_value,
  input  logic [lge_pkg::RadW-1:0]      radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          cell_read,
  output logic [lge_pkg::CountW-1:0]    population,
  output logic [lge_pkg::GenW-1:0]      generation
);
  import lge_pkg::*;

  state_t state, state_next;

  logic [SideW-1:0]  gw, gh;
  logic [IdxW-1:0]   wm1, hm1;
  action_t           act_q;
  logic [IdxW-1:0]   ccol, crow;
  logic              val_q, inb;
  logic [CountW-1:0] live, n_acc;
  logic [GenW-1:0]   gen;
  logic              rd_bit;
  logic [AddrW-1:0]  sweep;
  logic              clear_all, rc_pend, rc_v;
  logic [IdxW-1:0]   px, py, x_lo, x_hi, y_hi;
  logic [SideW-1:0]  p;
  logic [1:0]        ph;
  logic [IdxW-1:0]   r;
  logic [2:0]        wl, wm, save0;
  logic              t_cur, t_below;

  // ram ports
  logic              g_we, g_re, g_wdata, g_rdata;
  logic [AddrW-1:0]  g_waddr, g_raddr;
  logic              c_we, c_re;
  logic [IdxW-1:0]   c_waddr, c_raddr;
  logic [CacheW-1:0] c_wdata, c_rdata;

  logic              in_fire, out_load;
  logic [IdxW-1:0]   j, r_below;
  logic [2:0]        tn, right;
  logic [3:0]        k;
  logic              newv;

  assign wm1 = gw[IdxW-1:0] - 1'b1;
  assign hm1 = gh[IdxW-1:0] - 1'b1;
  assign in_ready = (state == S_IDLE) && !rc_pend && !cfg_we;
  assign in_fire = in_valid && in_ready;
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  // paint bounds and cell range check from the incoming word
  logic [RadW-1:0]   rad_c;
  logic [CoordW-1:0] xl, yl;
  logic [CoordW:0]   xh, yh;
  logic [IdxW-1:0]   xhc, yhc;
  logic              paint_empty, in_grid;

  always_comb begin
    rad_c = (radius > RadW'(MaxRadius)) ? RadW'(MaxRadius) : radius;
    xl = (col >= CoordW'(rad_c)) ? col - CoordW'(rad_c) : '0;
    yl = (row >= CoordW'(rad_c)) ? row - CoordW'(rad_c) : '0;
    xh = {1'b0, col} + (CoordW+1)'(rad_c);
    yh = {1'b0, row} + (CoordW+1)'(rad_c);
    xhc = (xh >= (CoordW+1)'(gw)) ? wm1 : xh[IdxW-1:0];
    yhc = (yh >= (CoordW+1)'(gh)) ? hm1 : yh[IdxW-1:0];
    paint_empty = (xl >= CoordW'(gw)) || (yl >= CoordW'(gh));
    in_grid = (col < CoordW'(gw)) && (row < CoordW'(gh));
  end

  // generation window: triple is {above, cur, below}
  always_comb begin
    j = (p == '0) ? wm1 : IdxW'(p - 1'b1);
    r_below = (r == hm1) ? '0 : r + 1'b1;
    tn = {(r == '0) ? g_rdata : c_rdata[0], t_cur, t_below};
    right = (state == S_GEN_TAIL) ? save0 : tn;
    k = 4'(wl[0]) + 4'(wl[1]) + 4'(wl[2]) + 4'(right[0]) + 4'(right[1]) +
        4'(right[2]) + 4'(wm[2]) + 4'(wm[0]);
    newv = life_rule(wm[1], k);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram controls
  always_comb begin
    state_next = state;
    g_we = 1'b0; g_waddr = '0; g_wdata = 1'b0;
    g_re = 1'b0; g_raddr = '0;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0;
    c_re = 1'b0; c_raddr = '0;
    case (state)
      S_CLEAR: begin
        g_we = clear_all || ({1'b0, sweep[AddrW-1:IdxW]} >= gh) ||
               ({1'b0, sweep[IdxW-1:0]} >= gw);
        g_waddr = sweep;
        if (sweep == '1) state_next = clear_all ? S_IDLE : S_FINISH;
      end
      S_IDLE: begin
        if (rc_pend) begin
          state_next = S_RECOUNT;
        end else if (in_fire) begin
          case (action_t'(action))
            ACT_PAINT: state_next = paint_empty ? S_FINISH : S_PAINT_RD;
            ACT_STEP:  state_next = S_GEN;
            default:   state_next = S_CELL_RD;
          endcase
        end
      end
      S_RECOUNT: begin
        g_re = 1'b1;
        g_raddr = sweep;
        if (sweep == '1) state_next = S_RCDRAIN;
      end
      S_RCDRAIN: state_next = S_IDLE;
      S_CELL_RD: begin
        g_re = 1'b1;
        g_raddr = {crow, ccol};
        state_next = S_CELL_WR;
      end
      S_CELL_WR: begin
        g_we = (act_q == ACT_WRITE) && inb && (g_rdata != val_q);
        g_waddr = {crow, ccol};
        g_wdata = val_q;
        state_next = S_FINISH;
      end
      S_PAINT_RD: begin
        g_re = 1'b1;
        g_raddr = {py, px};
        state_next = S_PAINT_WR;
      end
      S_PAINT_WR: begin
        g_we = !g_rdata;
        g_waddr = {py, px};
        g_wdata = 1'b1;
        state_next = ((px == x_hi) && (py == y_hi)) ? S_FINISH : S_PAINT_RD;
      end
      S_GEN: begin
        case (ph)
          2'd0: begin
            g_re = 1'b1; g_raddr = {r, j};
            c_re = 1'b1; c_raddr = j;
          end
          2'd1: begin
            g_re = 1'b1; g_raddr = {r_below, j};
          end
          2'd2: begin
            g_re = 1'b1; g_raddr = {hm1, j};
          end
          default: begin
            c_we = (p != '0);
            c_waddr = j;
            c_wdata = {(r == '0) ? t_cur : c_rdata[1], t_cur};
            g_we = (p >= SideW'(2));
            g_waddr = {r, IdxW'(p - SideW'(2))};
            g_wdata = newv;
            if (p == gw) state_next = S_GEN_TAIL;
          end
        endcase
      end
      S_GEN_TAIL: begin
        g_we = 1'b1;
        g_waddr = {r, wm1};
        g_wdata = newv;
        state_next = (r == hm1) ? S_CLEAR : S_GEN;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      clear_all <= 1'b1;
      live      <= '0;
      gen       <= '0;
      gw        <= SideW'(MaxSide);
      gh        <= SideW'(MaxSide);
      rc_pend   <= 1'b0;
      rc_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1 && !clear_all) begin
            live <= n_acc;
            gen  <= gen + 1'b1;
          end
        end
        S_IDLE: begin
          rc_v <= 1'b0;
          if (rc_pend) begin
            sweep   <= '0;
            n_acc   <= '0;
            if (!cfg_we) rc_pend <= 1'b0;
          end else if (in_fire) begin
            act_q  <= action_t'(action);
            ccol   <= col[IdxW-1:0];
            crow   <= row[IdxW-1:0];
            val_q  <= cell_value;
            inb    <= in_grid;
            rd_bit <= 1'b0;
            px     <= xl[IdxW-1:0];
            x_lo   <= xl[IdxW-1:0];
            x_hi   <= xhc;
            py     <= yl[IdxW-1:0];
            y_hi   <= yhc;
            p      <= '0;
            ph     <= '0;
            r      <= '0;
            n_acc  <= '0;
          end
        end
        S_RECOUNT: begin
          sweep <= sweep + 1'b1;
          rc_v  <= ({1'b0, sweep[AddrW-1:IdxW]} < gh) && ({1'b0, sweep[IdxW-1:0]} < gw);
          n_acc <= n_acc + CountW'(rc_v && g_rdata);
        end
        S_RCDRAIN: live <= n_acc + CountW'(rc_v && g_rdata);
        S_CELL_WR: begin
          rd_bit <= (act_q == ACT_READ) && inb && g_rdata;
          if ((act_q == ACT_WRITE) && inb && (g_rdata != val_q)) begin
            live <= val_q ? live + 1'b1 : live - 1'b1;
          end
        end
        S_PAINT_WR: begin
          if (!g_rdata) live <= live + 1'b1;
          if (px == x_hi) begin
            px <= x_lo;
            py <= py + 1'b1;
          end else begin
            px <= px + 1'b1;
          end
        end
        S_GEN: begin
          ph <= ph + 1'b1;
          if (ph == 2'd1) t_cur <= g_rdata;
          if (ph == 2'd2) t_below <= (r == hm1) ? c_rdata[1] : g_rdata;
          if (ph == 2'd3) begin
            wl <= wm;
            wm <= tn;
            if (p == SideW'(1)) save0 <= tn;
            if (p >= SideW'(2)) n_acc <= n_acc + CountW'(newv);
            p <= p + 1'b1;
          end
        end
        S_GEN_TAIL: begin
          n_acc <= n_acc + CountW'(newv);
          p     <= '0;
          ph    <= '0;
          r     <= r + 1'b1;
          if (r == hm1) begin
            sweep     <= '0;
            clear_all <= 1'b0;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_valid  <= 1'b1;
            cell_read  <= rd_bit;
            population <= live;
            generation <= gen;
          end
        end
        default: ;
      endcase
      // register writes; the user must write only while idle, the block does not enforce it
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) gw <= clamp_side(cfg_data);
        else gh <= clamp_side(cfg_data);
        rc_pend <= 1'b1;
      end
    end
  end

  // cell grid, one bit per cell, row major
  lge_ram #(
    .Width (1),
    .Depth (GridDepth)
  ) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // row cache: {original row 0, original previous row} per column
  lge_ram #(
    .Width (CacheW),
    .Depth (MaxSide)
  ) u_cache (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // checks
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !g_we) else $error("grid write while idle");
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CountW'(GridDepth)) else $error("live count out of range");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE) else $error("word accepted but idle");
  a_gen_window: assert property (@(posedge clk) disable iff (rst)
    state == S_GEN |-> p <= gw) else $error("column sweep past grid width");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the life grid engine. The testbench keeps its own copy of the grid,
// applies every accepted word to it and compares each result word with the
// oldest prediction. Grid size registers are rewritten between phases.
// Idle gaps and stalls fall at random on both channels.
// ----------------------------------------------------------------------------
module tb;
  import lge_pkg::*;

  localparam int unsigned CycleLimit = 20_000_000;

  typedef struct packed {
    logic              rd;
    logic [CountW-1:0] pop;
    logic [GenW-1:0]   gen;
  } life_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [SideW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_READ;
  logic [CoordW-1:0] col = '0;
  logic [CoordW-1:0] row = '0;
  logic cell_value = 1'b0;
  logic [RadW-1:0] radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic cell_read;
  logic [CountW-1:0] population;
  logic [GenW-1:0] generation;

  // model of the grid
  bit cells [GridDepth];
  int unsigned cols_used = MaxSide;
  int unsigned rows_used = MaxSide;
  logic [CountW-1:0] live_cells = '0;
  logic [GenW-1:0] gen_count = '0;

  life_result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  life_grid_engine_core u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned fit_side(logic [SideW-1:0] v);
    if (v < 3) return 3;
    if (v > MaxSide) return MaxSide;
    return v;
  endfunction

  function automatic void count_live();
    int unsigned n;
    n = 0;
    for (int r = 0; r < rows_used; r++)
      for (int c = 0; c < cols_used; c++) n += cells[r*MaxSide+c];
    live_cells = CountW'(n);
  endfunction

  function automatic void set_cell(int x, int y, bit v);
    if (x < 0 || y < 0 || x >= cols_used || y >= rows_used) return;
    if (cells[y*MaxSide+x] != v) begin
      if (v) live_cells++;
      else live_cells--;
      cells[y*MaxSide+x] = v;
    end
  endfunction

  function automatic void next_generation();
    bit nxt [GridDepth];
    int k, n, xx, yy;
    n = 0;
    for (int r = 0; r < MaxSide; r++)
      for (int c = 0; c < MaxSide; c++) begin
        nxt[r*MaxSide+c] = 1'b0;
        if (r < rows_used && c < cols_used) begin
          k = 0;
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
              if (dx != 0 || dy != 0) begin
                xx = (c + dx + cols_used) % cols_used;
                yy = (r + dy + rows_used) % rows_used;
                k += cells[yy*MaxSide+xx];
              end
          nxt[r*MaxSide+c] = (k == 3) || (cells[r*MaxSide+c] && k == 2);
          n += nxt[r*MaxSide+c];
        end
      end
    cells = nxt;
    live_cells = CountW'(n);
    gen_count++;
  endfunction

  function automatic life_result_t apply_action(action_t a, int x, int y, bit v, int rad);
    life_result_t res;
    int rr;
    res.rd = 1'b0;
    case (a)
      ACT_WRITE: set_cell(x, y, v);
      ACT_PAINT: begin
        rr = (rad > MaxRadius) ? MaxRadius : rad;
        for (int dy = -rr; dy <= rr; dy++)
          for (int dx = -rr; dx <= rr; dx++) set_cell(x + dx, y + dy, 1'b1);
      end
      ACT_STEP: next_generation();
      default: begin
        if (x < cols_used && y < rows_used) res.rd = cells[y*MaxSide+x];
      end
    endcase
    res.pop = live_cells;
    res.gen = gen_count;
    return res;
  endfunction

  // send one word, then an optional idle gap
  task automatic send_word(action_t a, int x, int y, bit v, int rad);
    int gap;
    pending_results.push_back(apply_action(a, x, y, v, rad));
    in_valid <= 1'b1;
    action <= a;
    col <= CoordW'(x);
    row <= CoordW'(y);
    cell_value <= v;
    radius <= RadW'(rad);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, then wait out the recount pass
  task automatic write_reg(logic idx, int unsigned v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= SideW'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) cols_used = fit_side(SideW'(v));
    else rows_used = fit_side(SideW'(v));
    count_live();
    repeat (4) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stalls on the result side
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = $urandom_range(0, 9);
      if (n < 4) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (n < 9) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    life_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        want = pending_results.pop_front();
        if (want.rd !== cell_read || want.pop !== population || want.gen !== generation) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: cell %0d/%0d pop %0d/%0d gen %0d/%0d (expected/actual)",
                     want.rd, cell_read, want.pop, population, want.gen, generation);
        end
      end
    end
  end

  // full grid: corners, out of range writes, clamped paint, one big step
  task automatic test_full_grid();
    send_word(ACT_WRITE, 255, 255, 1, 0);
    send_word(ACT_READ, 255, 255, 0, 0);
    send_word(ACT_WRITE, 256, 3, 1, 0);
    send_word(ACT_WRITE, 1023, 1023, 1, 63);
    send_word(ACT_READ, 1023, 512, 0, 0);
    send_word(ACT_PAINT, 0, 0, 0, 63);
    send_word(ACT_PAINT, 254, 1, 0, 0);
    send_word(ACT_WRITE, 0, 0, 0, 0);
    send_word(ACT_READ, 0, 0, 1, 0);
    send_word(ACT_WRITE, 200, 200, 1, 0);
    send_word(ACT_STEP, 0, 0, 0, 0);
    send_word(ACT_READ, 255, 255, 0, 0);
    send_word(ACT_WRITE, 200, 200, 1, 0);
  endtask

  // smallest grid, clamped from below; hidden cells cleared by a step
  task automatic test_tiny_grid();
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 2);
    send_word(ACT_READ, 200, 200, 0, 0);
    send_word(ACT_WRITE, 3, 0, 1, 0);
    send_word(ACT_WRITE, 0, 1, 1, 0);
    send_word(ACT_WRITE, 1, 1, 1, 0);
    send_word(ACT_WRITE, 2, 1, 1, 0);
    send_word(ACT_STEP, 0, 0, 0, 0);
    write_reg(CFG_WIDTH, 511);
    write_reg(CFG_HEIGHT, 257);
    send_word(ACT_READ, 200, 200, 0, 0);
    send_word(ACT_READ, 1, 1, 0, 0);
  endtask

  // glider across the wrap edges of a small grid
  task automatic test_glider();
    write_reg(CFG_WIDTH, 10);
    write_reg(CFG_HEIGHT, 6);
    send_word(ACT_WRITE, 9, 4, 1, 0);
    send_word(ACT_WRITE, 0, 5, 1, 0);
    send_word(ACT_WRITE, 8, 0, 1, 0);
    send_word(ACT_WRITE, 9, 0, 1, 0);
    send_word(ACT_WRITE, 0, 0, 1, 0);
    send_word(ACT_STEP, 0, 0, 0, 0);
    send_word(ACT_STEP, 0, 0, 0, 0);
    send_word(ACT_READ, 0, 0, 0, 0);
  endtask

  // random words on a mid sized grid
  task automatic test_random();
    int n, x, y;
    write_reg(CFG_WIDTH, 16);
    write_reg(CFG_HEIGHT, 12);
    for (int i = 0; i < 70; i++) begin
      n = $urandom_range(0, 99);
      x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 17);
      y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 13);
      if (n < 40) send_word(ACT_WRITE, x, y, $urandom_range(0, 1), $urandom_range(0, 63));
      else if (n < 52) send_word(ACT_PAINT, x, y, $urandom_range(0, 1), $urandom_range(0, 63));
      else if (n < 58) send_word(ACT_STEP, x, y, $urandom_range(0, 1), $urandom_range(0, 63));
      else send_word(ACT_READ, x, y, $urandom_range(0, 1), $urandom_range(0, 63));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_grid();
    test_tiny_grid();
    test_glider();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/lge_pkg.sv
hw/rtl/lge_ram.sv
hw/rtl/life_grid_engine_core.sv
test/tb.sv
